// ===== rtl/core/grp_pkg.sv =====
package grp_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic wr;
        logic seed;
        logic rotate;
    } grid_ctl_t;

endpackage

// ===== rtl/core/grp_row_unit.sv =====
module grp_row_unit #(
    parameter int GRID_WIDTH = 9
) (
    input  logic [GRID_WIDTH-1:0] cur_row,
    input  logic [GRID_WIDTH-1:0] above_row,
    input  logic [GRID_WIDTH-1:0] below_row,
    input  logic [GRID_WIDTH-1:0] occ_row,
    input  logic                  first_row,
    input  logic                  last_row,
    output logic [GRID_WIDTH-1:0] row_new,
    output logic                  changed
);

    localparam int SW = $clog2(GRID_WIDTH);

    logic [GRID_WIDTH-1:0] empty;
    logic [GRID_WIDTH-1:0] vert;
    logic [GRID_WIDTH-1:0] seed;
    logic [GRID_WIDTH-1:0] gen_l;
    logic [GRID_WIDTH-1:0] pro_l;
    logic [GRID_WIDTH-1:0] gen_r;
    logic [GRID_WIDTH-1:0] pro_r;

    assign empty = ~occ_row;

    always_comb
    begin
        vert = '0;
        if (!first_row)
        begin
            vert = vert | above_row;
        end
        if (!last_row)
        begin
            vert = vert | below_row;
        end
        seed  = cur_row | (empty & vert);
        gen_l = seed;
        pro_l = empty;
        gen_r = seed;
        pro_r = empty;
        // spread along runs of empty cells in both directions
        for (int i = 0; i < SW; i++)
        begin
            gen_l = gen_l | (pro_l & (gen_l << (1 << i)));
            pro_l = pro_l & (pro_l << (1 << i));
            gen_r = gen_r | (pro_r & (gen_r >> (1 << i)));
            pro_r = pro_r & (pro_r >> (1 << i));
        end
        row_new = gen_l | gen_r;
        changed = (row_new != cur_row);
    end

endmodule

// ===== rtl/core/grp_grid.sv =====
module grp_grid import grp_pkg::*; #(
    parameter int GRID_WIDTH  = 9,
    parameter int GRID_HEIGHT = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  grid_ctl_t                      ctl,
    input  logic [$clog2(GRID_WIDTH)-1:0]  x_idx,
    input  logic [$clog2(GRID_HEIGHT)-1:0] y_idx,
    input  logic                           wr_occ,
    input  logic [$clog2(GRID_WIDTH)-1:0]  tx_idx,
    input  logic [$clog2(GRID_HEIGHT)-1:0] ty_idx,
    input  logic [GRID_WIDTH-1:0]          row_new,
    output logic [GRID_WIDTH-1:0]          cur_row,
    output logic [GRID_WIDTH-1:0]          above_row,
    output logic [GRID_WIDTH-1:0]          below_row,
    output logic [GRID_WIDTH-1:0]          occ_row,
    output logic                           hit
);

    localparam int YW = $clog2(GRID_HEIGHT);

    logic [GRID_WIDTH-1:0] occ_reg   [GRID_HEIGHT];
    logic [GRID_WIDTH-1:0] reach_reg [GRID_HEIGHT];

    assign cur_row   = reach_reg[0];
    assign below_row = reach_reg[1];
    assign above_row = reach_reg[GRID_HEIGHT-1];
    assign occ_row   = occ_reg[0];
    assign hit       = reach_reg[ty_idx][tx_idx];

    // rotate both maps one row per cycle; slot 0 is the row under work
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GRID_HEIGHT; i++)
            begin
                occ_reg[i] <= '0;
            end
        end
        else if (ctl.rotate)
        begin
            for (int i = 0; i < GRID_HEIGHT - 1; i++)
            begin
                occ_reg[i] <= occ_reg[i+1];
            end
            occ_reg[GRID_HEIGHT-1] <= occ_reg[0];
        end
        else if (ctl.wr)
        begin
            occ_reg[y_idx][x_idx] <= wr_occ;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.seed)
        begin
            for (int i = 0; i < GRID_HEIGHT; i++)
            begin
                if (YW'(i) == y_idx)
                begin
                    reach_reg[i] <= GRID_WIDTH'(1) << x_idx;
                end
                else
                begin
                    reach_reg[i] <= '0;
                end
            end
        end
        else if (ctl.rotate)
        begin
            for (int i = 0; i < GRID_HEIGHT - 1; i++)
            begin
                reach_reg[i] <= reach_reg[i+1];
            end
            reach_reg[GRID_HEIGHT-1] <= row_new;
        end
    end

    a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rotate |-> !ctl.wr && !ctl.seed)
        else $error("grid write or seed during sweep");

    a_rotate_keeps_occ: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rotate |=> occ_reg[GRID_HEIGHT-1] == $past(occ_reg[0]))
        else $error("occupancy row lost in rotation");

    a_seed_marks_start: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.seed |=> reach_reg[$past(y_idx)][$past(x_idx)])
        else $error("start cell not marked");

endmodule

// ===== rtl/core/grid_path_reachability.sv =====
// Four-neighbor reachability on a GRID_WIDTH x GRID_HEIGHT occupancy map (9 x 9 by
// default, all cells empty after reset). A write word (operation 0) sets or clears
// one cell; a write outside the grid is dropped. A query word (operation 1) floods
// from the start cell through empty cells and returns one reachable word; the
// start cell's own occupancy is ignored, and a start or target outside the grid
// answers 0 without a sweep. The flood runs through one shared row unit that
// updates one row per cycle while the map rotates past it, and the sweep repeats
// full row passes until a pass changes nothing (at least one, plus one for each
// row the flood has to climb upward). in_stall is high for the whole query,
// including while its result waits for the output register to drain; a write
// word is accepted while a result is pending.
module grid_path_reachability import grp_pkg::*; #(
    parameter int GRID_WIDTH  = 9,
    parameter int GRID_HEIGHT = 9
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       operation,
    input  logic [3:0] cell_x,
    input  logic [3:0] cell_y,
    input  logic       occupied,
    input  logic [3:0] target_x,
    input  logic [3:0] target_y,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       reachable
);

    localparam int XW = $clog2(GRID_WIDTH);
    localparam int YW = $clog2(GRID_HEIGHT);
    localparam logic [YW-1:0] LAST_ROW = YW'(GRID_HEIGHT - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SWEEP  = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [YW-1:0]         row_reg, row_next;
    logic                  dirty_reg, dirty_next;
    logic                  out_valid_reg, out_valid_next;
    logic [XW-1:0]         tx_reg, tx_next;
    logic [YW-1:0]         ty_reg, ty_next;
    logic                  qok_reg, qok_next;
    logic                  res_reg, res_next;

    logic                  in_accept;
    logic                  start_ok;
    logic                  target_ok;
    grid_ctl_t             ctl;
    logic [GRID_WIDTH-1:0] cur_row;
    logic [GRID_WIDTH-1:0] above_row;
    logic [GRID_WIDTH-1:0] below_row;
    logic [GRID_WIDTH-1:0] occ_row;
    logic [GRID_WIDTH-1:0] row_new;
    logic                  changed;
    logic                  hit;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign reachable = res_reg;

    assign start_ok  = (32'(cell_x) < 32'(GRID_WIDTH)) && (32'(cell_y) < 32'(GRID_HEIGHT));
    assign target_ok = (32'(target_x) < 32'(GRID_WIDTH)) && (32'(target_y) < 32'(GRID_HEIGHT));

    assign ctl.wr     = in_accept && (operation == OP_WRITE) && start_ok;
    assign ctl.seed   = in_accept && (operation == OP_QUERY) && start_ok && target_ok;
    assign ctl.rotate = (state_reg == ST_SWEEP);

    grp_grid #(
        .GRID_WIDTH (GRID_WIDTH),
        .GRID_HEIGHT(GRID_HEIGHT)
    ) u_grid (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .x_idx    (XW'(cell_x)),
        .y_idx    (YW'(cell_y)),
        .wr_occ   (occupied),
        .tx_idx   (tx_reg),
        .ty_idx   (ty_reg),
        .row_new  (row_new),
        .cur_row  (cur_row),
        .above_row(above_row),
        .below_row(below_row),
        .occ_row  (occ_row),
        .hit      (hit)
    );

    grp_row_unit #(
        .GRID_WIDTH(GRID_WIDTH)
    ) u_row_unit (
        .cur_row  (cur_row),
        .above_row(above_row),
        .below_row(below_row),
        .occ_row  (occ_row),
        .first_row(row_reg == '0),
        .last_row (row_reg == LAST_ROW),
        .row_new  (row_new),
        .changed  (changed)
    );

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        dirty_next     = dirty_reg;
        out_valid_next = out_valid_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        qok_next       = qok_reg;
        res_next       = res_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.seed)
                begin
                    state_next = ST_SWEEP;
                    row_next   = '0;
                    dirty_next = 1'b0;
                    tx_next    = XW'(target_x);
                    ty_next    = YW'(target_y);
                    qok_next   = 1'b1;
                end
                else if (in_accept && (operation == OP_QUERY))
                begin
                    state_next = ST_FINISH;
                    qok_next   = 1'b0;
                end
            end
            ST_SWEEP:
            begin
                if (row_reg == LAST_ROW)
                begin
                    row_next   = '0;
                    dirty_next = 1'b0;
                    if (!(dirty_reg || changed))
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    row_next   = row_reg + YW'(1);
                    dirty_next = dirty_reg || changed;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    res_next       = qok_reg && hit;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            dirty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            dirty_reg     <= dirty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tx_reg  <= tx_next;
        ty_reg  <= ty_next;
        qok_reg <= qok_next;
        res_reg <= res_next;
    end

    a_query_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.seed |=> (state_reg == ST_SWEEP) && (row_reg == '0) && !dirty_reg)
        else $error("valid query did not start a sweep");

    a_sweep_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) && (row_reg != LAST_ROW)
        |=> (state_reg == ST_SWEEP) && (row_reg == $past(row_reg) + YW'(1)))
        else $error("sweep left before pass end");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result loaded outside finish");

    a_finish_clean_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) && (state_next == ST_FINISH) |-> !dirty_reg && !changed)
        else $error("sweep ended on a changing pass");

endmodule
